// ----- design/dqpm_pkg.sv -----
`timescale 1ns / 1ps

package dqpm_pkg;

    // Field widths of one item and one result
    localparam int OPCODE_W    = 3;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_CNT_W = 5;

    // Request opcodes; the unused code seven falls to the default arm
    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_MAX    = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_PEEK_FRONT = 3'd6
    } t_opcode;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT
    } t_state;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [STATUS_W-1:0]       status;
        logic [ENTRY_CNT_W-1:0]    entry_count;
    } t_out_item;

    // Controls of the shared compare unit
    typedef struct packed {
        logic init;
        logic step;
    } t_cmp_ctl;

endpackage

// ----- design/dqpm_mem.sv -----
`timescale 1ns / 1ps

module dqpm_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [AW-1:0]                        i_waddr,
    input  logic signed [dqpm_pkg::VALUE_W-1:0]  i_wdata,
    input  logic                                 i_re,
    input  logic [AW-1:0]                        i_raddr,
    output logic signed [dqpm_pkg::VALUE_W-1:0]  o_rdata
);

    logic signed [dqpm_pkg::VALUE_W-1:0] r_mem [DEPTH];
    logic signed [dqpm_pkg::VALUE_W-1:0] r_rdata;

    // Write one entry per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/dqpm_max_unit.sv -----
`timescale 1ns / 1ps

module dqpm_max_unit #(
    parameter int IW = 5
) (
    input  logic                                 i_clk,
    input  dqpm_pkg::t_cmp_ctl                   i_ctl,
    input  logic signed [dqpm_pkg::VALUE_W-1:0]  i_cand_val,
    input  logic [IW-1:0]                        i_cand_idx,
    output logic signed [dqpm_pkg::VALUE_W-1:0]  o_best_val,
    output logic [IW-1:0]                        o_best_idx
);

    logic signed [dqpm_pkg::VALUE_W-1:0] r_best_val;
    logic [IW-1:0]                       r_best_idx;
    logic                                cand_wins;

    // Strictly greater only, so the earliest entry keeps a tie
    assign cand_wins = i_cand_val > r_best_val;

    // Load the first candidate, then keep the running maximum
    always_ff @(posedge i_clk) begin
        if (i_ctl.init || (i_ctl.step && cand_wins)) begin
            r_best_val <= i_cand_val;
            r_best_idx <= i_cand_idx;
        end
    end

    assign o_best_val = r_best_val;
    assign o_best_idx = r_best_idx;

endmodule

// ----- design/deque_with_pop_max.sv -----
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values with pop-max.
// Input channel: present i_item (opcode, push_value) with start high; the item
// is taken at a rising edge where start is high and busy is low. busy stays
// high while the item is worked on.
// Result channel: o_done pulses for one cycle with o_result (result_value,
// status, entry_count). The receiver cannot stall; each result is seen once.
// Sequencing: pushes, pops and peeks pass through S_EXEC alone; busy falls and
// the result shows in the same cycle, and a new item can be taken in that
// cycle. Pop-max on an empty or one-entry queue is the same.
// Pop-max with n >= 2 entries held keeps busy high through two passes: one pass
// reads every held entry into the shared compare unit, a second pass moves the
// entries behind the maximum one place toward the front. Both passes are paced
// by the single read port of the entry store, one entry per cycle.
// Reset (i_rst_n low at a clock edge) empties the queue and drops any item in
// flight; the store contents need no clearing, only held entries are read.
module deque_with_pop_max #(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  dqpm_pkg::t_in_item   i_item,
    output logic                 busy,
    output logic                 o_done,
    output dqpm_pkg::t_out_item  o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    dqpm_pkg::t_state                    r_state, n_state;
    logic [dqpm_pkg::OPCODE_W-1:0]       r_op, n_op;
    logic signed [dqpm_pkg::VALUE_W-1:0] r_val, n_val;
    logic [CW-1:0]                       r_count, n_count;
    logic [AW-1:0]                       r_front, n_front;
    logic [CW-1:0]                       r_k, n_k;
    logic                                r_done, n_done;
    dqpm_pkg::t_out_item                 r_out, n_out;

    logic                                mem_we;
    logic [AW-1:0]                       mem_waddr;
    logic signed [dqpm_pkg::VALUE_W-1:0] mem_wdata;
    logic                                mem_re;
    logic [AW-1:0]                       mem_raddr;
    logic signed [dqpm_pkg::VALUE_W-1:0] mem_rdata;

    dqpm_pkg::t_cmp_ctl                  cmp_ctl;
    logic [CW-1:0]                       cmp_idx;
    logic signed [dqpm_pkg::VALUE_W-1:0] best_val;
    logic [CW-1:0]                       best_idx;

    // Store index of the entry k places behind the front
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(f) + SW'(k);
        if (s >= SW'(DEPTH)) begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    dqpm_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    dqpm_max_unit #(
        .IW (CW)
    ) u_max (
        .i_clk      (i_clk),
        .i_ctl      (cmp_ctl),
        .i_cand_val (mem_rdata),
        .i_cand_idx (cmp_idx),
        .o_best_val (best_val),
        .o_best_idx (best_idx)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqpm_pkg::S_IDLE;
            r_count <= '0;
            r_front <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_front <= n_front;
            r_done  <= n_done;
        end
    end

    // Payload and scan index
    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_val <= n_val;
        r_k   <= n_k;
        r_out <= n_out;
    end

    // Sequence each item through the store and the compare unit
    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_val     = r_val;
        n_count   = r_count;
        n_front   = r_front;
        n_k       = r_k;
        n_done    = 1'b0;
        n_out     = r_out;
        mem_we    = 1'b0;
        mem_waddr = r_front;
        mem_wdata = r_val;
        mem_re    = 1'b0;
        mem_raddr = r_front;
        cmp_ctl   = '0;
        cmp_idx   = r_k;

        case (r_state)
            dqpm_pkg::S_IDLE: begin
                // Take the item and start the read it will need
                if (start) begin
                    n_op    = i_item.opcode;
                    n_val   = i_item.push_value;
                    n_state = dqpm_pkg::S_EXEC;
                    if (r_count != '0) begin
                        mem_re = 1'b1;
                        if (i_item.opcode == dqpm_pkg::OP_POP_BACK ||
                            i_item.opcode == dqpm_pkg::OP_PEEK_BACK) begin
                            mem_raddr = slot(r_front, r_count - CW'(1));
                        end
                    end
                end
            end

            dqpm_pkg::S_EXEC: begin
                n_state                = dqpm_pkg::S_IDLE;
                n_done                 = 1'b1;
                n_out.result_value     = '0;
                n_out.status           = dqpm_pkg::ST_OK;
                n_out.entry_count      = dqpm_pkg::ENTRY_CNT_W'(r_count);
                case (r_op)
                    dqpm_pkg::OP_PUSH_BACK: begin
                        if (r_count == FULL_CNT) begin
                            n_out.status = dqpm_pkg::ST_FULL;
                        end else begin
                            mem_we            = 1'b1;
                            mem_waddr         = slot(r_front, r_count);
                            n_count           = r_count + CW'(1);
                            n_out.entry_count = dqpm_pkg::ENTRY_CNT_W'(n_count);
                        end
                    end
                    dqpm_pkg::OP_PUSH_FRONT: begin
                        if (r_count == FULL_CNT) begin
                            n_out.status = dqpm_pkg::ST_FULL;
                        end else begin
                            n_front           = (r_front == '0) ? LAST_SLOT
                                                                : r_front - AW'(1);
                            mem_we            = 1'b1;
                            mem_waddr         = n_front;
                            n_count           = r_count + CW'(1);
                            n_out.entry_count = dqpm_pkg::ENTRY_CNT_W'(n_count);
                        end
                    end
                    dqpm_pkg::OP_POP_BACK, dqpm_pkg::OP_POP_FRONT,
                    dqpm_pkg::OP_PEEK_BACK, dqpm_pkg::OP_PEEK_FRONT: begin
                        if (r_count == '0) begin
                            n_out.status = dqpm_pkg::ST_EMPTY;
                        end else begin
                            n_out.result_value = mem_rdata;
                            if (r_op == dqpm_pkg::OP_POP_BACK ||
                                r_op == dqpm_pkg::OP_POP_FRONT) begin
                                n_count           = r_count - CW'(1);
                                n_out.entry_count = dqpm_pkg::ENTRY_CNT_W'(n_count);
                            end
                            if (r_op == dqpm_pkg::OP_POP_FRONT) begin
                                n_front = (r_front == LAST_SLOT) ? '0
                                                                 : r_front + AW'(1);
                            end
                        end
                    end
                    dqpm_pkg::OP_POP_MAX: begin
                        if (r_count == '0) begin
                            n_out.status = dqpm_pkg::ST_EMPTY;
                        end else if (r_count == CW'(1)) begin
                            // A single entry is the maximum; nothing to close up
                            n_out.result_value = mem_rdata;
                            n_count            = '0;
                            n_out.entry_count  = '0;
                        end else begin
                            // Seed the compare unit with the front entry
                            cmp_ctl.init = 1'b1;
                            cmp_idx      = '0;
                            mem_re       = 1'b1;
                            mem_raddr    = slot(r_front, CW'(1));
                            n_k          = CW'(1);
                            n_done       = 1'b0;
                            n_state      = dqpm_pkg::S_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            dqpm_pkg::S_SCAN: begin
                // Compare entry k, fetch entry k + 1
                cmp_ctl.step = 1'b1;
                if (SW'(r_k) + SW'(1) < SW'(r_count)) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot(r_front, r_k + CW'(1));
                    n_k       = r_k + CW'(1);
                end else begin
                    n_state = dqpm_pkg::S_SHIFT_RD;
                end
            end

            dqpm_pkg::S_SHIFT_RD: begin
                if (SW'(best_idx) + SW'(1) < SW'(r_count)) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot(r_front, best_idx + CW'(1));
                    n_k       = best_idx;
                    n_state   = dqpm_pkg::S_SHIFT;
                end else begin
                    n_state            = dqpm_pkg::S_IDLE;
                    n_done             = 1'b1;
                    n_count            = r_count - CW'(1);
                    n_out.result_value = best_val;
                    n_out.status       = dqpm_pkg::ST_OK;
                    n_out.entry_count  = dqpm_pkg::ENTRY_CNT_W'(n_count);
                end
            end

            dqpm_pkg::S_SHIFT: begin
                // Move entry k + 1 into place k, fetch entry k + 2
                mem_we    = 1'b1;
                mem_waddr = slot(r_front, r_k);
                mem_wdata = mem_rdata;
                if (SW'(r_k) + SW'(2) < SW'(r_count)) begin
                    mem_re    = 1'b1;
                    mem_raddr = slot(r_front, r_k + CW'(2));
                    n_k       = r_k + CW'(1);
                end else begin
                    n_state            = dqpm_pkg::S_IDLE;
                    n_done             = 1'b1;
                    n_count            = r_count - CW'(1);
                    n_out.result_value = best_val;
                    n_out.status       = dqpm_pkg::ST_OK;
                    n_out.entry_count  = dqpm_pkg::ENTRY_CNT_W'(n_count);
                end
            end

            default: begin
                n_state = dqpm_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != dqpm_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule
